### hw/rtl/rtdsla_pkg.sv
// Shared types, constants and the RTD conversion table for the slew-limited average block.
// No dependencies; every other file in hw/rtl imports this package.
package rtdsla_pkg;

   localparam int DEF_WINDOW_LEN = 16;
   localparam int TABLE_ENTRIES  = 161;

   localparam int SAMPLE_W = 12;
   localparam int TEMP_W   = 8;
   localparam int IDX_W    = 8;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_STEP_LIMIT = 1'b0;
   localparam logic [SAMPLE_W-1:0] STEP_LIMIT_RESET = 12'd100;

   // Lookup bounds and results.
   localparam logic [SAMPLE_W-1:0] LOOK_MIN = 12'd209;
   localparam logic [SAMPLE_W-1:0] LOOK_MAX = 12'd2520;
   localparam logic signed [IDX_W:0] SEARCH_HI = 9'sd159;
   localparam logic signed [IDX_W:0] DEG_OFFSET = 9'sd40;
   localparam logic signed [TEMP_W-1:0] OUT_OF_RANGE = -8'sd41;

   // Table entry i is the ADC code at (i - 40) degrees Celsius.
   localparam logic [SAMPLE_W-1:0] RTD_ROM [TABLE_ENTRIES] = '{
      12'd209,  12'd222,  12'd238,  12'd255,  12'd269,
      12'd283,  12'd294,  12'd310,  12'd325,  12'd340,
      12'd355,  12'd370,  12'd386,  12'd401,  12'd415,
      12'd430,  12'd448,  12'd460,  12'd477,  12'd491,
      12'd505,  12'd520,  12'd536,  12'd548,  12'd564,
      12'd578,  12'd594,  12'd610,  12'd622,  12'd638,
      12'd650,  12'd668,  12'd685,  12'd699,  12'd714,
      12'd726,  12'd740,  12'd755,  12'd772,  12'd786,
      12'd800,  12'd816,  12'd832,  12'd845,  12'd860,
      12'd875,  12'd887,  12'd902,  12'd917,  12'd932,
      12'd947,  12'd963,  12'd979,  12'd991,  12'd1006,
      12'd1027, 12'd1036, 12'd1050, 12'd1065, 12'd1078,
      12'd1095, 12'd1100, 12'd1124, 12'd1138, 12'd1153,
      12'd1167, 12'd1176, 12'd1195, 12'd1212, 12'd1225,
      12'd1240, 12'd1255, 12'd1270, 12'd1280, 12'd1298,
      12'd1313, 12'd1327, 12'd1345, 12'd1356, 12'd1371,
      12'd1382, 12'd1400, 12'd1414, 12'd1429, 12'd1443,
      12'd1458, 12'd1472, 12'd1484, 12'd1458, 12'd1515,
      12'd1529, 12'd1545, 12'd1558, 12'd1573, 12'd1588,
      12'd1600, 12'd1615, 12'd1630, 12'd1643, 12'd1660,
      12'd1670, 12'd1685, 12'd1700, 12'd1715, 12'd1729,
      12'd1744, 12'd1755, 12'd1770, 12'd1785, 12'd1801,
      12'd1816, 12'd1829, 12'd1843, 12'd1855, 12'd1870,
      12'd1885, 12'd1900, 12'd1915, 12'd1927, 12'd1942,
      12'd1958, 12'd1972, 12'd1987, 12'd2000, 12'd2013,
      12'd2028, 12'd2041, 12'd2059, 12'd2072, 12'd2085,
      12'd2098, 12'd2116, 12'd2128, 12'd2145, 12'd2156,
      12'd2171, 12'd2186, 12'd2196, 12'd2215, 12'd2225,
      12'd2240, 12'd2255, 12'd2270, 12'd2281, 12'd2295,
      12'd2310, 12'd2325, 12'd2339, 12'd2350, 12'd2365,
      12'd2379, 12'd2395, 12'd2410, 12'd2420, 12'd2435,
      12'd2451, 12'd2465, 12'd2477, 12'd2491, 12'd2505,
      12'd2520
   };

endpackage

### hw/rtl/rtdsla_ifs.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on rtdsla_pkg for field widths.
interface rtdsla_req_if;
   import rtdsla_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

interface rtdsla_rsp_if;
   import rtdsla_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [SAMPLE_W-1:0]       filtered_value;
   logic signed [TEMP_W-1:0]  temperature_c;

   modport source (output valid, output filtered_value, output temperature_c, input ready);
   modport sink (input valid, input filtered_value, input temperature_c, output ready);
endinterface

### hw/rtl/rtd_slew_limited_average_lookup_core.sv
// Top level: slew-limited moving average of RTD samples with temperature table search.
// Depends on rtdsla_pkg, the channel interfaces in rtdsla_ifs.sv and rtdsla_csr.
//
//   channel  direction  handshake              payload
//   req_chan in         valid/ready            raw_sample
//   rsp_chan out        valid/ready            filtered_value, temperature_c
//   psel..   in         APB write/read         step_limit at byte address 0
//
// One beat passes through accept, clamp and read, the window update (add, then subtract),
// a reciprocal multiply for the average, a range check, then for in-range values a binary
// search of the table that ends on a match or when it is exhausted, and loading of the result.
// When the running sum is zero the window is first refilled, every slot with the sample.
// The fill and the window update share one add/sub unit; the search compares against one
// pair of neighbouring table entries per cycle. req_chan.ready is high only while idle;
// a result that is not taken holds the next one in the finish state. Reset is synchronous.
module rtd_slew_limited_average_lookup_core #(
   parameter int WINDOW_LEN = rtdsla_pkg::DEF_WINDOW_LEN
) (
   input  logic                                clock,
   input  logic                                reset,
   rtdsla_req_if.sink                          req_chan,
   rtdsla_rsp_if.source                        rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rtdsla_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rtdsla_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rtdsla_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);
   import rtdsla_pkg::*;

   localparam int SUM_W  = $clog2(WINDOW_LEN * 4095 + 1);
   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   // The average is the sum times a rounded-up reciprocal, shifted down; with this
   // shift the quotient is exact for every sum that fits in SUM_W bits.
   localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP       = (2 ** RECIP_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int RECIP_W     = SUM_W + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILL, ST_READ, ST_ADD, ST_SUB, ST_DIV, ST_CHECK, ST_SEARCH, ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [SAMPLE_W-1:0]        avg_ff, avg_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [SLOT_W-1:0]          fill_ff, fill_in;
   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic [SAMPLE_W-1:0]        clamped_ff, clamped_in;
   logic signed [IDX_W:0]      lo_ff, lo_in;
   logic signed [IDX_W:0]      hi_ff, hi_in;
   logic signed [TEMP_W-1:0]   temp_ff, temp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_filt_ff, rsp_filt_in;
   logic signed [TEMP_W-1:0]   rsp_temp_ff, rsp_temp_in;

   logic [SAMPLE_W-1:0]        step_limit;
   logic [SAMPLE_W-1:0]        win_mem [WINDOW_LEN];
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic                       mem_we;
   logic [SLOT_W-1:0]          mem_addr;
   logic [SAMPLE_W-1:0]        mem_wdata;

   logic [SUM_W:0]             alu_a, alu_b, alu_res;
   logic                       alu_sub;
   logic [PROD_W-1:0]          recip_prod;

   logic [SAMPLE_W:0]          upper_wide;
   logic [SAMPLE_W-1:0]        upper, lower;
   logic signed [IDX_W+1:0]    lohi_sum;
   logic [IDX_W-1:0]           mid, mid_next;
   logic [SAMPLE_W-1:0]        rom_a, rom_b;
   logic                       rsp_load;

   rtdsla_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .step_limit (step_limit)
   );

   // Clamp bounds: the average plus the limit saturates at full scale, minus it at zero.
   assign upper_wide = {1'b0, avg_ff} + {1'b0, step_limit};
   assign upper = upper_wide[SAMPLE_W] ? {SAMPLE_W{1'b1}} : upper_wide[SAMPLE_W-1:0];
   assign lower = (avg_ff >= step_limit) ? (avg_ff - step_limit) : '0;

   // Search midpoint; lo stays non-negative while the search runs, while hi may fall to -1.
   assign lohi_sum = {lo_ff[IDX_W], lo_ff} + {hi_ff[IDX_W], hi_ff};
   assign mid      = lohi_sum[IDX_W:1];
   assign mid_next = mid + 8'd1;
   assign rom_a    = RTD_ROM[mid];
   assign rom_b    = RTD_ROM[mid_next];

   assign recip_prod = PROD_W'(sum_ff) * PROD_W'(RECIP);

   // The shared add/subtract unit serves the fill and the window update.
   always_comb begin
      alu_sub = 1'b0;
      alu_a   = {1'b0, sum_ff};
      alu_b   = '0;
      case (state_ff)
         ST_FILL: begin
            alu_b = (SUM_W+1)'(sample_ff);
         end
         ST_ADD: begin
            alu_b = (SUM_W+1)'(clamped_ff);
         end
         ST_SUB: begin
            alu_sub = 1'b1;
            alu_b   = (SUM_W+1)'(rd_data_ff);
         end
         default: begin
            alu_b = '0;
         end
      endcase
      alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   end

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sample_in    = sample_ff;
      clamped_in   = clamped_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      temp_in      = temp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_filt_in  = rsp_filt_ff;
      rsp_temp_in  = rsp_temp_ff;
      mem_we       = 1'b0;
      mem_addr     = slot_ff;
      mem_wdata    = clamped_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sample_in = req_chan.raw_sample;
               if (sum_ff == '0) begin
                  // An empty window is first refilled with this sample.
                  avg_in   = req_chan.raw_sample;
                  fill_in  = '0;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_addr  = fill_ff;
            mem_wdata = sample_ff;
            sum_in    = alu_res[SUM_W-1:0];
            fill_in   = fill_ff + 1'b1;
            if (fill_ff == SLOT_W'(WINDOW_LEN - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (sample_ff > upper) begin
               clamped_in = upper;
            end else if (sample_ff < lower) begin
               clamped_in = lower;
            end else begin
               clamped_in = sample_ff;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            mem_we   = 1'b1;
            sum_in   = alu_res[SUM_W-1:0];
            state_in = ST_SUB;
         end
         ST_SUB: begin
            sum_in   = alu_res[SUM_W-1:0];
            slot_in  = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            avg_in   = recip_prod[RECIP_SHIFT +: SAMPLE_W];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            lo_in = '0;
            hi_in = SEARCH_HI;
            if (avg_ff < LOOK_MIN || avg_ff > LOOK_MAX) begin
               temp_in  = OUT_OF_RANGE;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (lo_ff > hi_ff) begin
               temp_in  = OUT_OF_RANGE;
               state_in = ST_FINISH;
            end else if (avg_ff >= rom_a && avg_ff < rom_b) begin
               temp_in  = TEMP_W'($signed({1'b0, mid}) - DEG_OFFSET);
               state_in = ST_FINISH;
            end else if (avg_ff < rom_a) begin
               hi_in = $signed({1'b0, mid}) - 9'sd1;
            end else if (avg_ff > rom_b) begin
               lo_in = $signed({1'b0, mid}) + 9'sd1;
            end else begin
               // The value equals the upper neighbor, which the search reports as its degree.
               temp_in  = TEMP_W'($signed({1'b0, mid_next}) - DEG_OFFSET);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = avg_ff;
               rsp_temp_in  = temp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         avg_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fill_ff     <= fill_in;
      sample_ff   <= sample_in;
      clamped_ff  <= clamped_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      temp_ff     <= temp_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   // Window memory: one write port, one registered read of the oldest slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[mem_addr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= win_mem[slot_ff];
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_value = rsp_filt_ff;
   assign rsp_chan.temperature_c  = rsp_temp_ff;

   // The new average is the truncated quotient of the sum by the window length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |->
         ((sum_ff - SUM_W'(avg_ff) * SUM_W'(WINDOW_LEN)) < SUM_W'(WINDOW_LEN)))
      else $error("average is not the window sum over its length");

   // Search bounds are checked: lo stays from 0 to 160 and hi at most 159.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (hi_ff <= SEARCH_HI && lo_ff <= 9'sd160 && lo_ff >= 9'sd0))
      else $error("search bounds left the table");

   // A waiting result holds the next one back.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == ST_FINISH))
      else $error("result overwrote an untaken beat");

   // The reported filtered value is the average the next sample is clamped against.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_filt_ff == avg_ff && rsp_valid_ff))
      else $error("reported value differs from the stored average");

endmodule

### hw/rtl/rtdsla_csr.sv
// APB-style register slave holding the step limit.
// Depends on rtdsla_pkg for address and data widths.
module rtdsla_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rtdsla_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rtdsla_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rtdsla_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready,
   output logic [rtdsla_pkg::SAMPLE_W-1:0]     step_limit
);
   import rtdsla_pkg::*;

   logic [SAMPLE_W-1:0] step_limit_ff;
   logic [SAMPLE_W-1:0] step_limit_in;
   logic                reg_hit;

   // Bit 2 of the byte address selects the register; word offsets are ignored.
   assign reg_hit = (paddr[2] == REG_STEP_LIMIT);

   always_comb begin
      step_limit_in = step_limit_ff;
      if (psel && penable && pwrite && reg_hit) begin
         step_limit_in = pwdata[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff <= STEP_LIMIT_RESET;
      end else begin
         step_limit_ff <= step_limit_in;
      end
   end

   assign pready     = 1'b1;
   assign prdata     = reg_hit ? {{(CSR_DATA_W-SAMPLE_W){1'b0}}, step_limit_ff} : '0;
   assign step_limit = step_limit_ff;

endmodule
